// ===== rtl/pmt_pkg.sv =====
// Shared types and constants of the prescaled match timer.
`timescale 1ns / 1ps

package pmt_pkg;

  // Width of a register word on the request and result channels.
  localparam int unsigned DataW = 32;
  // Width of the stored divider setting.
  localparam int unsigned DivW = 8;

  // Request action codes.
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;

  // Register word offsets.
  localparam logic [2:0] REG_CTL       = 3'd0;
  localparam logic [2:0] REG_COUNT     = 3'd1;
  localparam logic [2:0] REG_PRESCALE  = 3'd2;
  localparam logic [2:0] REG_PRE_COUNT = 3'd3;
  localparam logic [2:0] REG_MATCH     = 3'd4;
  localparam logic [2:0] REG_DIVIDER   = 3'd5;
  localparam logic [2:0] REG_IRQ_CTL   = 3'd6;
  localparam logic [2:0] REG_STATUS    = 3'd7;

  // Bit positions within the control, interrupt control and status words.
  localparam int unsigned CTL_ENABLE_BIT   = 0;
  localparam int unsigned IC_ENABLE_BIT    = 0;
  localparam int unsigned IC_DISABLE_BIT   = 8;
  localparam int unsigned IC_CLR_MATCH_BIT = 16;
  localparam int unsigned IC_CLR_WRAP_BIT  = 17;
  localparam int unsigned ST_MATCH_BIT     = 0;
  localparam int unsigned ST_WRAP_BIT      = 2;

  // One result of a request.
  typedef struct packed {
    logic [DataW-1:0] read_data;
    logic             irq;
  } pmt_result_t;

  // Flag state exported by the register file.
  typedef struct packed {
    logic run_enable;
    logic match_irq_enable;
    logic match_pending;
    logic wrap_pending;
  } pmt_status_t;

endpackage

// ===== rtl/prescaled_match_timer.sv =====
// Top level of the prescaled match timer.
`timescale 1ns / 1ps

// The timer takes one request per clock cycle (a tick, a register read or a
// register write) and gives exactly one result per request: the read data
// (zero for ticks and writes) and the irq level after the request. The
// register update is a single pass of logic at acceptance; the result is
// registered in the result register, or in the skid stage if that is full.
// The two-entry output buffer lets requests keep flowing while a result
// waits; req_ready drops only when both entries are full.

module prescaled_match_timer #(
  parameter int unsigned COUNTER_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic [1:0]  action,
  input  logic [2:0]  reg_index,
  input  logic [31:0] write_data,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic [31:0] read_data,
  output logic        irq
);
  import pmt_pkg::*;

  logic        take;
  pmt_result_t new_result;
  pmt_result_t rsp_data;
  pmt_status_t status;

  assign take = req_valid & req_ready;

  // Register file and per-request logic.
  pmt_regs #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_regs (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .action    (action),
    .reg_index (reg_index),
    .write_data(write_data),
    .result    (new_result),
    .status    (status)
  );

  // Output buffer.
  pmt_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (take),
    .push_data (new_result),
    .push_ready(req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

  assign read_data = rsp_data.read_data;
  assign irq       = rsp_data.irq;

`ifndef SYNTHESIS
  // Back-pressure only happens with a result waiting at the output.
  a_ready_implies_result: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> rsp_valid)
    else $error("request blocked with no result pending");

  // A tick while stopped leaves all flags unchanged.
  a_stopped_tick: assert property (@(posedge clk) disable iff (rst)
    (take && action == ACT_TICK && !status.run_enable) |=> $stable(status))
    else $error("flags changed on a tick while stopped");

  // Clearing match pending through interrupt control takes effect at once.
  a_clear_match: assert property (@(posedge clk) disable iff (rst)
    (take && action == ACT_WRITE && reg_index == REG_IRQ_CTL &&
     write_data[IC_CLR_MATCH_BIT]) |=> !status.match_pending)
    else $error("match pending not cleared");
`endif

endmodule

// ===== rtl/pmt_regs.sv =====
// Timer register file: tick, read and write handling for one request.
`timescale 1ns / 1ps

module pmt_regs #(
  parameter int unsigned COUNTER_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      take,
  input  logic [1:0]                action,
  input  logic [2:0]                reg_index,
  input  logic [pmt_pkg::DataW-1:0] write_data,
  output pmt_pkg::pmt_result_t      result,
  output pmt_pkg::pmt_status_t      status
);
  import pmt_pkg::*;

  logic                     run_enable, run_enable_next;
  logic [COUNTER_WIDTH-1:0] count_value, count_value_next;
  logic [DataW-1:0]         prescale_value, prescale_value_next;
  logic [DataW-1:0]         prescale_count, prescale_count_next;
  logic [DataW-1:0]         match_value, match_value_next;
  logic [DivW-1:0]          divider_setting, divider_setting_next;
  logic                     match_irq_enable, match_irq_enable_next;
  logic                     match_pending, match_pending_next;
  logic                     wrap_pending, wrap_pending_next;
  logic [DataW-1:0]         read_word;

  // Next state and read data for the request at the port.
  always_comb begin
    run_enable_next       = run_enable;
    count_value_next      = count_value;
    prescale_value_next   = prescale_value;
    prescale_count_next   = prescale_count;
    match_value_next      = match_value;
    divider_setting_next  = divider_setting;
    match_irq_enable_next = match_irq_enable;
    match_pending_next    = match_pending;
    wrap_pending_next     = wrap_pending;
    read_word             = '0;
    case (action)
      ACT_TICK: begin
        if (run_enable) begin
          // A prescale count at or above the limit counts as reached.
          if (prescale_count >= prescale_value) begin
            prescale_count_next = '0;
            count_value_next    = count_value + 1'b1;
            if (&count_value) begin
              wrap_pending_next = 1'b1;
            end
            if (DataW'(count_value_next) == match_value) begin
              match_pending_next = 1'b1;
            end
          end else begin
            prescale_count_next = prescale_count + 1'b1;
          end
        end
      end
      ACT_READ: begin
        case (reg_index)
          REG_CTL:       read_word[CTL_ENABLE_BIT] = run_enable;
          REG_COUNT:     read_word = DataW'(count_value);
          REG_PRESCALE:  read_word = prescale_value;
          REG_PRE_COUNT: read_word = prescale_count;
          REG_MATCH:     read_word = match_value;
          REG_DIVIDER:   read_word = DataW'(divider_setting);
          REG_IRQ_CTL:   read_word[IC_ENABLE_BIT] = match_irq_enable;
          default: begin
            read_word[ST_MATCH_BIT] = match_pending;
            read_word[ST_WRAP_BIT]  = wrap_pending;
          end
        endcase
      end
      ACT_WRITE: begin
        case (reg_index)
          REG_CTL:       run_enable_next = write_data[CTL_ENABLE_BIT];
          REG_COUNT:     count_value_next = write_data[COUNTER_WIDTH-1:0];
          REG_PRESCALE:  prescale_value_next = write_data;
          REG_PRE_COUNT: prescale_count_next = write_data;
          REG_MATCH:     match_value_next = write_data;
          REG_DIVIDER:   divider_setting_next = write_data[DivW-1:0];
          REG_IRQ_CTL: begin
            // Disable wins over enable when both bits are set.
            if (write_data[IC_ENABLE_BIT]) begin
              match_irq_enable_next = 1'b1;
            end
            if (write_data[IC_DISABLE_BIT]) begin
              match_irq_enable_next = 1'b0;
            end
            if (write_data[IC_CLR_MATCH_BIT]) begin
              match_pending_next = 1'b0;
            end
            if (write_data[IC_CLR_WRAP_BIT]) begin
              wrap_pending_next = 1'b0;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // The result reflects the state after the request.
  assign result.read_data = read_word;
  assign result.irq       = match_pending_next & match_irq_enable_next;

  assign status.run_enable       = run_enable;
  assign status.match_irq_enable = match_irq_enable;
  assign status.match_pending    = match_pending;
  assign status.wrap_pending     = wrap_pending;

  // State registers, updated once per accepted request.
  always_ff @(posedge clk) begin
    if (rst) begin
      run_enable       <= 1'b0;
      count_value      <= '0;
      prescale_value   <= '0;
      prescale_count   <= '0;
      match_value      <= '0;
      divider_setting  <= '0;
      match_irq_enable <= 1'b0;
      match_pending    <= 1'b0;
      wrap_pending     <= 1'b0;
    end else if (take) begin
      run_enable       <= run_enable_next;
      count_value      <= count_value_next;
      prescale_value   <= prescale_value_next;
      prescale_count   <= prescale_count_next;
      match_value      <= match_value_next;
      divider_setting  <= divider_setting_next;
      match_irq_enable <= match_irq_enable_next;
      match_pending    <= match_pending_next;
      wrap_pending     <= wrap_pending_next;
    end
  end

endmodule

// ===== rtl/pmt_skid.sv =====
// Result register with a skid stage towards the result channel.
`timescale 1ns / 1ps

module pmt_skid (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  pmt_pkg::pmt_result_t push_data,
  output logic                 push_ready,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output pmt_pkg::pmt_result_t rsp_data
);
  import pmt_pkg::*;

  logic        out_valid;
  pmt_result_t out_data;
  logic        skid_valid;
  pmt_result_t skid_data;
  logic        pop;

  assign pop        = out_valid & rsp_ready;
  assign push_ready = ~skid_valid;
  assign rsp_valid  = out_valid;
  assign rsp_data   = out_data;

  // Valid flags of the two entries.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= push;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      if (out_valid) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end
  end

  // Payload of the two entries; the older result always sits in front.
  always_ff @(posedge clk) begin
    if (pop && skid_valid) begin
      out_data <= skid_data;
      if (push) begin
        skid_data <= push_data;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_data <= push_data;
      end else begin
        out_data <= push_data;
      end
    end
  end

endmodule
